// ===== hw/rtl/fprx_pkg.sv =====
`timescale 1ns / 1ps

package fprx_pkg;

   // Field widths
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 7;
   localparam int IDX_W  = 6;
   localparam int STAT_W = 2;
   localparam int CSR_W  = 2;

   // Result status codes
   localparam logic [STAT_W-1:0] ST_PAYLOAD = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STAT_W-1:0] ST_ERROR   = 2'd2;

   // Register indexes
   localparam logic [CSR_W-1:0] CSR_FIRST_SYNC  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_SECOND_SYNC = 2'd1;
   localparam logic [CSR_W-1:0] CSR_LEN_LIMIT   = 2'd2;
   localparam logic [CSR_W-1:0] CSR_DELIVER_EN  = 2'd3;

   // Register reset values
   localparam logic [BYTE_W-1:0] RST_FIRST_SYNC  = 8'd188;
   localparam logic [BYTE_W-1:0] RST_SECOND_SYNC = 8'd207;
   localparam logic [LEN_W-1:0]  RST_LEN_LIMIT   = 7'd64;

   typedef struct packed {
      logic [BYTE_W-1:0] first_sync;
      logic [BYTE_W-1:0] second_sync;
      logic [LEN_W-1:0]  length_limit;
      logic              deliver_en;
   } cfg_type;

   // One job handed from the parser to the drain side
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [BYTE_W-1:0] ptype;
      logic [LEN_W-1:0]  plen;
   } job_type;

endpackage

// ===== hw/rtl/fprx_ram.sv =====
`timescale 1ns / 1ps

module fprx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/fprx_front.sv =====
`timescale 1ns / 1ps

module fprx_front
   import fprx_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64,
   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  logic              q_full,
   input  logic              drain_busy,
   output logic              q_push,
   output job_type           q_job,
   output logic              ram_wr_en,
   output logic [ADDR_W-1:0] ram_wr_addr,
   output logic [BYTE_W-1:0] ram_wr_data
);

   localparam logic [2:0] HS_FIRST  = 3'd0;
   localparam logic [2:0] HS_SECOND = 3'd1;
   localparam logic [2:0] HS_TYPE   = 3'd2;
   localparam logic [2:0] HS_LEN    = 3'd3;
   localparam logic [2:0] HS_DATA   = 3'd4;
   localparam logic [2:0] HS_CK1    = 3'd5;
   localparam logic [2:0] HS_CK2    = 3'd6;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

   logic [2:0]        state_ff, state_in;
   logic [BYTE_W-1:0] type_ff, type_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic [BYTE_W-1:0] sum_a_ff, sum_a_in;
   logic [BYTE_W-1:0] sum_b_ff, sum_b_in;

   logic              accept;
   logic [LEN_W-1:0]  limit;
   logic [BYTE_W-1:0] sum_a_next;
   logic [LEN_W-1:0]  fill_next;

   // Hold off payload bytes while the store is still being drained
   assign req_ready = !q_full && !((state_ff == HS_DATA) && drain_busy);
   assign accept    = req_valid && req_ready;

   assign limit      = (cfg.length_limit > MAX_LEN) ? MAX_LEN : cfg.length_limit;
   assign sum_a_next = sum_a_ff + req_rx_byte;
   assign fill_next  = fill_ff + LEN_W'(1);

   assign ram_wr_addr = fill_ff[ADDR_W-1:0];
   assign ram_wr_data = req_rx_byte;

   // Frame parser
   always_comb begin
      state_in  = state_ff;
      type_in   = type_ff;
      len_in    = len_ff;
      fill_in   = fill_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      q_push    = 1'b0;
      q_job     = '{status: ST_ERROR, ptype: type_ff, plen: len_ff};
      ram_wr_en = 1'b0;
      if (accept) begin
         if (req_kind) begin
            state_in = HS_FIRST;
         end else begin
            unique case (state_ff)
               HS_FIRST: begin
                  state_in = (req_rx_byte == cfg.first_sync) ? HS_SECOND : HS_FIRST;
               end
               HS_SECOND: begin
                  state_in = (req_rx_byte == cfg.second_sync) ? HS_TYPE : HS_FIRST;
               end
               HS_TYPE: begin
                  type_in  = req_rx_byte;
                  sum_a_in = req_rx_byte;
                  sum_b_in = req_rx_byte;
                  state_in = HS_LEN;
               end
               HS_LEN: begin
                  if (req_rx_byte <= {1'b0, limit}) begin
                     len_in   = req_rx_byte[LEN_W-1:0];
                     sum_a_in = sum_a_next;
                     sum_b_in = sum_b_ff + sum_a_next;
                     fill_in  = '0;
                     state_in = (req_rx_byte != '0) ? HS_DATA : HS_CK1;
                  end else begin
                     state_in = HS_FIRST;
                  end
               end
               HS_DATA: begin
                  ram_wr_en = 1'b1;
                  sum_a_in  = sum_a_next;
                  sum_b_in  = sum_b_ff + sum_a_next;
                  fill_in   = fill_next;
                  if (fill_next >= len_ff) begin
                     state_in = HS_CK1;
                  end
               end
               HS_CK1: begin
                  if (req_rx_byte == sum_a_ff) begin
                     state_in = HS_CK2;
                  end else begin
                     q_push   = 1'b1;
                     state_in = HS_FIRST;
                  end
               end
               HS_CK2: begin
                  if (req_rx_byte == sum_b_ff) begin
                     q_push       = cfg.deliver_en;
                     q_job.status = (len_ff == '0) ? ST_EMPTY : ST_PAYLOAD;
                  end else begin
                     q_push = 1'b1;
                  end
                  state_in = HS_FIRST;
               end
               default: begin
                  state_in = HS_FIRST;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HS_FIRST;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff  <= type_in;
      len_ff   <= len_in;
      fill_ff  <= fill_in;
      sum_a_ff <= sum_a_in;
      sum_b_ff <= sum_b_in;
   end

endmodule

// ===== hw/rtl/fprx_queue.sv =====
`timescale 1ns / 1ps

module fprx_queue
   import fprx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type pop_job,
   output logic    full,
   output logic    empty
);

   job_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign pop_job = slot_ff[rd_ptr_ff];

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== hw/rtl/fprx_back.sv =====
`timescale 1ns / 1ps

module fprx_back
   import fprx_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64,
   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  job_type           q_job,
   output logic              q_pop,
   output logic              busy,
   output logic              ram_rd_en,
   output logic [ADDR_W-1:0] ram_rd_addr,
   input  logic [BYTE_W-1:0] ram_rd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [STAT_W-1:0] rsp_status,
   output logic [BYTE_W-1:0] rsp_packet_type,
   output logic [LEN_W-1:0]  rsp_packet_length,
   output logic [IDX_W-1:0]  rsp_byte_index,
   output logic [BYTE_W-1:0] rsp_payload_byte,
   output logic              rsp_last
);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_LOAD = 2'd1;
   localparam logic [1:0] B_WAIT = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic [BYTE_W-1:0] type_ff, type_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              valid_ff, valid_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [BYTE_W-1:0] otype_ff, otype_in;
   logic [LEN_W-1:0]  olen_ff, olen_in;
   logic [IDX_W-1:0]  oidx_ff, oidx_in;
   logic [BYTE_W-1:0] obyte_ff, obyte_in;
   logic              last_ff, last_in;
   logic [LEN_W-1:0]  idx_next;

   assign idx_next = idx_ff + LEN_W'(1);
   assign busy     = (state_ff != B_IDLE);

   // Drain sequencer: one store read, then one result transfer
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      type_in     = type_ff;
      len_in      = len_ff;
      valid_in    = valid_ff;
      status_in   = status_ff;
      otype_in    = otype_ff;
      olen_in     = olen_ff;
      oidx_in     = oidx_ff;
      obyte_in    = obyte_ff;
      last_in     = last_ff;
      q_pop       = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[ADDR_W-1:0];
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               type_in = q_job.ptype;
               len_in  = q_job.plen;
               if (q_job.status == ST_PAYLOAD) begin
                  idx_in      = '0;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = '0;
                  state_in    = B_LOAD;
               end else begin
                  valid_in  = 1'b1;
                  status_in = q_job.status;
                  otype_in  = q_job.ptype;
                  olen_in   = q_job.plen;
                  oidx_in   = '0;
                  obyte_in  = '0;
                  last_in   = 1'b1;
                  state_in  = B_WAIT;
               end
            end
         end
         B_LOAD: begin
            valid_in  = 1'b1;
            status_in = ST_PAYLOAD;
            otype_in  = type_ff;
            olen_in   = len_ff;
            oidx_in   = idx_ff[IDX_W-1:0];
            obyte_in  = ram_rd_data;
            last_in   = (idx_next == len_ff);
            state_in  = B_WAIT;
         end
         B_WAIT: begin
            if (rsp_ready) begin
               valid_in = 1'b0;
               if (last_ff) begin
                  state_in = B_IDLE;
               end else begin
                  idx_in      = idx_next;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = idx_next[ADDR_W-1:0];
                  state_in    = B_LOAD;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      type_ff   <= type_in;
      len_ff    <= len_in;
      status_ff <= status_in;
      otype_ff  <= otype_in;
      olen_ff   <= olen_in;
      oidx_ff   <= oidx_in;
      obyte_ff  <= obyte_in;
      last_ff   <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_packet_type   = otype_ff;
   assign rsp_packet_length = olen_ff;
   assign rsp_byte_index    = oidx_ff;
   assign rsp_payload_byte  = obyte_ff;
   assign rsp_last          = last_ff;

endmodule

// ===== hw/rtl/framed_packet_receiver_unit.sv =====
`timescale 1ns / 1ps

// Channel | Ports                                   | Transfer when
// --------+-----------------------------------------+------------------------------
// req     | req_kind, req_rx_byte                   | req_valid && req_ready
// rsp     | rsp_status .. rsp_last (six fields)     | rsp_valid && rsp_ready
// csr     | csr_index, csr_wdata                    | csr_wr_en high
//
// One cycle per received byte in the parser; a two-entry job queue lets hunting
// go on while results wait, and a full queue stalls every byte.
// A status result passes through the job queue and the output register; each
// payload byte takes a store read, then the output register until it is taken.
// Payload bytes of a new frame stall while the drain side is busy or a job waits.
// Reset is synchronous; it clears the parser, the queue and the output valid.

module framed_packet_receiver_unit
   import fprx_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [STAT_W-1:0] rsp_status,
   output logic [BYTE_W-1:0] rsp_packet_type,
   output logic [LEN_W-1:0]  rsp_packet_length,
   output logic [IDX_W-1:0]  rsp_byte_index,
   output logic [BYTE_W-1:0] rsp_payload_byte,
   output logic              rsp_last,
   input  logic              csr_wr_en,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [BYTE_W-1:0] csr_wdata
);

   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   cfg_type           cfg_ff;
   logic              q_push;
   logic              q_pop;
   logic              q_full;
   logic              q_empty;
   job_type           push_job;
   job_type           pop_job;
   logic              back_busy;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [BYTE_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_sync   <= RST_FIRST_SYNC;
         cfg_ff.second_sync  <= RST_SECOND_SYNC;
         cfg_ff.length_limit <= RST_LEN_LIMIT;
         cfg_ff.deliver_en   <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FIRST_SYNC:  cfg_ff.first_sync   <= csr_wdata;
            CSR_SECOND_SYNC: cfg_ff.second_sync  <= csr_wdata;
            CSR_LEN_LIMIT:   cfg_ff.length_limit <= csr_wdata[LEN_W-1:0];
            CSR_DELIVER_EN:  cfg_ff.deliver_en   <= csr_wdata[0];
            default:         cfg_ff              <= cfg_ff;
         endcase
      end
   end

   fprx_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .drain_busy  (back_busy || !q_empty),
      .q_push      (q_push),
      .q_job       (push_job),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   fprx_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   fprx_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_PAYLOAD)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fprx_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_job             (pop_job),
      .q_pop             (q_pop),
      .busy              (back_busy),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_packet_type   (rsp_packet_type),
      .rsp_packet_length (rsp_packet_length),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_last          (rsp_last)
   );

`ifndef SYNTH
   // The store is never overwritten while a packet is being drained
   a_no_write_while_drain: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !back_busy && q_empty)
      else $error("payload store written during drain");

   // A job is never pushed into a full queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job pushed into full queue");

   // Empty-packet and error results always close their run
   a_single_results_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_PAYLOAD) |-> rsp_last)
      else $error("status result without last mark");

   // A store read is issued only by the drain side while it owns the store
   a_read_owned: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> !ram_wr_en)
      else $error("store read and write in the same cycle");
`endif

endmodule
